### rtl/core/oidd_pkg.sv
// ---------------------------------------------------------------------------
// oidd_pkg
// Shared types, constants and helpers for the BER OID subidentifier decoder.
// ---------------------------------------------------------------------------
package oidd_pkg;

    // Size of the value list; subidentifiers past this are flagged as extra
    localparam int MAX_VALUES = 16;

    // Seen counter saturates at MAX_VALUES + 1
    localparam int VS_W = $clog2(MAX_VALUES + 2);

    // Field widths fixed by the port list
    localparam int IDX_W = 5;
    localparam int ACC_W = 32;
    localparam int DIG_W = 7;

    // Decoupling queue between front and back
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // Final status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_UNTRM = 2'd1,
        STAT_OVER  = 2'd2
    } oidd_status_t;

    // One classified content octet as it travels from front to back
    typedef struct packed {
        logic [DIG_W-1:0] digit;
        logic             more;
        logic             last;
    } oidd_word_t;

    // Truncate a seen count to the 5-bit output field
    function automatic logic [IDX_W-1:0] fit_idx(input logic [VS_W-1:0] v);
        logic [VS_W+IDX_W-1:0] ext;
        ext = {{IDX_W{1'b0}}, v};
        return ext[IDX_W-1:0];
    endfunction

endpackage

### rtl/core/oidd_front.sv
// ---------------------------------------------------------------------------
// oidd_front
// Accepts content octets, splits them into digit and flags, and queues them.
// ---------------------------------------------------------------------------
module oidd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         content_byte,
    input  logic               final_byte,
    output logic               q_valid,
    output oidd_pkg::oidd_word_t q_word,
    input  logic               q_pop
);
    import oidd_pkg::*;

    oidd_word_t           q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 push;
    oidd_word_t           in_word;

    // Classify the incoming word
    assign in_word.digit = content_byte[DIG_W-1:0];
    assign in_word.more  = content_byte[7];
    assign in_word.last  = final_byte;

    // Stall only on a full queue
    assign byte_stall = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign push       = byte_valid && !byte_stall;

    assign q_valid = (count_reg != '0);
    assign q_word  = q_mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the queued word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_word;
        end
    end

    // Queue bookkeeping checks
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue fill count above depth");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

### rtl/core/oidd_back.sv
// ---------------------------------------------------------------------------
// oidd_back
// Accumulates subidentifier digits, tracks the value count and registers
// one result per completing or final octet.
// ---------------------------------------------------------------------------
module oidd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  oidd_pkg::oidd_word_t q_word,
    output logic                 q_pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [31:0]          subid_value,
    output logic [4:0]           subid_index,
    output logic                 subid_kept,
    output logic                 subid_valid,
    output logic                 oid_done,
    output logic [1:0]           oid_status,
    output logic [4:0]           value_count
);
    import oidd_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [VS_W-1:0]  vs_reg, vs_next;
    logic             res_valid_reg, res_valid_next;

    logic [ACC_W-1:0] val_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             kept_reg;
    logic             sval_reg;
    logic             done_reg;
    oidd_status_t     stat_reg;
    logic [IDX_W-1:0] cnt_reg;

    logic [ACC_W-1:0] acc_shift;
    logic [VS_W-1:0]  vs_after;
    logic             below_max;
    logic             need_out;
    logic             out_free;
    oidd_status_t     stat_c;
    logic [IDX_W-1:0] idx_c;
    logic [IDX_W-1:0] cnt_c;

    // Shift in the new digit
    assign acc_shift = {acc_reg[ACC_W-DIG_W-1:0], q_word.digit};
    assign below_max = (vs_reg < VS_W'(MAX_VALUES));

    // Pop when the word needs no output slot or the slot is free
    assign need_out = !q_word.more || q_word.last;
    assign out_free = !res_valid_reg || !result_stall;
    assign q_pop    = q_valid && (!need_out || out_free);

    // Compute count, status and next state
    always_comb
    begin
        vs_after = vs_reg;
        if (!q_word.more && (vs_reg <= VS_W'(MAX_VALUES)))
        begin
            vs_after = vs_reg + 1'b1;
        end

        idx_c = below_max ? fit_idx(vs_reg) : fit_idx(VS_W'(MAX_VALUES));

        if (q_word.more)
        begin
            stat_c = STAT_UNTRM;
        end
        else if (vs_after > VS_W'(MAX_VALUES))
        begin
            stat_c = STAT_OVER;
        end
        else
        begin
            stat_c = STAT_OK;
        end
        cnt_c = (stat_c == STAT_OK) ? fit_idx(vs_after) : '0;

        acc_next = acc_reg;
        vs_next  = vs_reg;
        if (q_pop)
        begin
            if (q_word.last)
            begin
                acc_next = '0;
                vs_next  = '0;
            end
            else if (!q_word.more)
            begin
                acc_next = '0;
                vs_next  = vs_after;
            end
            else
            begin
                acc_next = acc_shift;
            end
        end

        res_valid_next = res_valid_reg;
        if (q_pop && need_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            vs_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            vs_reg        <= vs_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (q_pop && need_out)
        begin
            sval_reg <= !q_word.more;
            val_reg  <= q_word.more ? '0 : acc_shift;
            idx_reg  <= q_word.more ? '0 : idx_c;
            kept_reg <= !q_word.more && below_max;
            done_reg <= q_word.last;
            stat_reg <= q_word.last ? stat_c : STAT_OK;
            cnt_reg  <= q_word.last ? cnt_c : '0;
        end
    end

    assign result_valid = res_valid_reg;
    assign subid_value  = val_reg;
    assign subid_index  = idx_reg;
    assign subid_kept   = kept_reg;
    assign subid_valid  = sval_reg;
    assign oid_done     = done_reg;
    assign oid_status   = stat_reg;
    assign value_count  = cnt_reg;

    // Result and state consistency checks
    a_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (subid_valid || oid_done))
        else $error("result with neither subidentifier nor done");

    a_kept_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && subid_kept) |-> subid_valid)
        else $error("kept mark without subidentifier");

    a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && oid_done && (oid_status != STAT_OK)) |-> (value_count == '0))
        else $error("nonzero count on error status");

    a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_word.last) |=> ((acc_reg == '0) && (vs_reg == '0)))
        else $error("state not cleared after final octet");

    a_vs_sat: assert property (@(posedge clk) disable iff (!rst_n)
        vs_reg <= VS_W'(MAX_VALUES + 1))
        else $error("seen count past saturation");

endmodule

### rtl/core/ber_oid_subidentifier_decoder.sv
// ---------------------------------------------------------------------------
// ber_oid_subidentifier_decoder
// Decodes BER OID content octets into subidentifiers and a final status.
// ---------------------------------------------------------------------------
// An accepted octet enters the queue, is popped into the accumulator or the result
//   register, and can wait queued under result_stall. Throughput: 1 octet per cycle
//   unless result_stall holds, set by the back-end shift-or and the 4-word queue.
// Reset: rst_n clears the queue, the accumulator, the value count and the
//   result valid flag; the block accepts octets in the first cycle after reset.
module ber_oid_subidentifier_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  content_byte,
    input  logic        final_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] subid_value,
    output logic [4:0]  subid_index,
    output logic        subid_kept,
    output logic        subid_valid,
    output logic        oid_done,
    output logic [1:0]  oid_status,
    output logic [4:0]  value_count
);
    import oidd_pkg::*;

    logic       q_valid;
    logic       q_pop;
    oidd_word_t q_word;

    // Front: accept and queue words
    oidd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .content_byte (content_byte),
        .final_byte   (final_byte),
        .q_valid      (q_valid),
        .q_word       (q_word),
        .q_pop        (q_pop)
    );

    // Back: accumulate and report
    oidd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_word       (q_word),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .subid_value  (subid_value),
        .subid_index  (subid_index),
        .subid_kept   (subid_kept),
        .subid_valid  (subid_valid),
        .oid_done     (oid_done),
        .oid_status   (oid_status),
        .value_count  (value_count)
    );

endmodule
